// ----- hdl/udf_pkg.sv -----
// ----------------------------------------------------------------------------
// udf_pkg
// Shared constants, emit codes and controller/datapath handshake structs for
// the unsigned decimal field formatter.
// ----------------------------------------------------------------------------
package udf_pkg;

  localparam int INPUT_VALUE_W  = 32;
  localparam int FIELD_W        = 6;
  localparam int CHAR_W         = 8;
  localparam int VALUE_BITS_DEF = 32;
  localparam int FIELD_MAX_DEF  = 63;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

  // What the datapath puts into the output register this cycle.
  localparam logic [2:0] EM_NONE  = 3'd0;
  localparam logic [2:0] EM_PAD   = 3'd1;
  localparam logic [2:0] EM_ZERO  = 3'd2;
  localparam logic [2:0] EM_DIGIT = 3'd3;
  localparam logic [2:0] EM_EMPTY = 3'd4;

  typedef struct packed {
    logic       in_ready;
    logic       conv_step;
    logic       setup;
    logic [2:0] emit_sel;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic q_zero;
    logic total_zero;
    logic left;
    logic pad_zero;
    logic pad_one;
    logic zeros_zero;
    logic zeros_one;
    logic dig_zero;
    logic dig_one;
    logic out_free;
  } status_t;

  // Decimal digits needed for the largest value of the given bit width.
  // 1233/4096 approximates log10(2) closely enough for widths up to 64.
  function automatic int digits_for_bits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

endpackage

// ----- hdl/udf_if.sv -----
// ----------------------------------------------------------------------------
// udf_in_if / udf_out_if
// Valid/ready channels carrying conversion requests and output characters.
// ----------------------------------------------------------------------------
interface udf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [5:0]  field_width;
  logic [5:0]  min_digits;
  logic        has_width;
  logic        has_precision;
  logic        zero_pad;
  logic        left_justify;

  modport source (
    output valid, value, field_width, min_digits, has_width, has_precision,
           zero_pad, left_justify,
    input  ready
  );
  modport sink (
    input  valid, value, field_width, min_digits, has_width, has_precision,
           zero_pad, left_justify,
    output ready
  );
endinterface

interface udf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic       empty_res;
  logic [5:0] char_count;

  modport source (
    output valid, character, last, empty_res, char_count,
    input  ready
  );
  modport sink (
    input  valid, character, last, empty_res, char_count,
    output ready
  );
endinterface

// ----- hdl/unsigned_decimal_field_formatter.sv -----
// ----------------------------------------------------------------------------
// unsigned_decimal_field_formatter
// printf-style %u conversion of one number into a stream of ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one conversion per item: the value, width and precision with
//   their presence flags, and the zero and minus flags. dout carries one
//   character per item; the final one has last set and the character count.
//   A conversion with no characters yields a single item with empty_res set.
//   Operation: after an item is taken, the digits are peeled off with one
//   divide-by-ten multiply per cycle, and a setup step then loads the field
//   counters. The left pad, zeros, digits and right pad phases then send
//   one character per cycle through the output register while it is free;
//   a phase with nothing to send passes through its own state without a
//   character. din is ready only between conversions, so the block takes
//   no new item until the last character of the current one is emitted.
//   The first character follows the digit extraction and setup steps.
//   A stalled receiver holds the output register and freezes emission; the
//   last character may still wait in that register while the next item is
//   accepted.
//   rst (synchronous) returns the sequencer to idle and drops dout.valid.
// ----------------------------------------------------------------------------
module unsigned_decimal_field_formatter #(
  parameter int FIELD_MAX  = udf_pkg::FIELD_MAX_DEF,
  parameter int VALUE_BITS = udf_pkg::VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  udf_in_if.sink    din,
  udf_out_if.source dout
);
  import udf_pkg::*;

  cmd_t    cmd;
  status_t status;

  udf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  udf_datapath #(
    .FIELD_MAX  (FIELD_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .din    (din),
    .dout   (dout)
  );

  // The block works on one conversion at a time.
  assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> !din.ready)
    else $error("input accepted while a conversion was in progress");

  assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.empty_res |-> dout.last && dout.char_count == 6'd0)
    else $error("empty result must be a lone last item with zero count");

  assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.last |-> dout.char_count == 6'd0)
    else $error("character count shown before the last item");

  assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.empty_res |->
      dout.character == ASCII_SPACE ||
      (dout.character >= ASCII_ZERO && dout.character <= 8'h39))
    else $error("emitted character is neither a digit nor a space");

endmodule

// ----- hdl/udf_ctrl.sv -----
// ----------------------------------------------------------------------------
// udf_ctrl
// Sequencer: digit extraction, field setup, then left padding, precision
// zeros, digits and right padding, one character per free output slot.
// ----------------------------------------------------------------------------
module udf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  udf_pkg::status_t status,
  output udf_pkg::cmd_t    cmd
);
  import udf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CONV   = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_PADL   = 3'd3;
  localparam logic [2:0] S_ZEROS  = 3'd4;
  localparam logic [2:0] S_DIGITS = 3'd5;
  localparam logic [2:0] S_PADR   = 3'd6;
  localparam logic [2:0] S_EMPTY  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.in_ready  = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.setup     = 1'b0;
    cmd.emit_sel  = EM_NONE;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.q_zero) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_PADL;
      end
      S_PADL: begin
        if (status.total_zero) begin
          state_next = S_EMPTY;
        end else if (status.left || status.pad_zero) begin
          state_next = S_ZEROS;
        end else if (status.out_free) begin
          cmd.emit_sel = EM_PAD;
          if (status.pad_one) begin
            state_next = S_ZEROS;
          end
        end
      end
      S_ZEROS: begin
        if (status.zeros_zero) begin
          state_next = S_DIGITS;
        end else if (status.out_free) begin
          cmd.emit_sel = EM_ZERO;
          if (status.zeros_one) begin
            state_next = S_DIGITS;
          end
        end
      end
      S_DIGITS: begin
        if (status.dig_zero) begin
          state_next = S_PADR;
        end else if (status.out_free) begin
          cmd.emit_sel = EM_DIGIT;
          if (status.dig_one) begin
            state_next = S_PADR;
          end
        end
      end
      S_PADR: begin
        // Left padding already drained the count unless left-justified.
        if (status.pad_zero) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit_sel = EM_PAD;
          if (status.pad_one) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (status.out_free) begin
          cmd.emit_sel = EM_EMPTY;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/udf_datapath.sv -----
// ----------------------------------------------------------------------------
// udf_datapath
// Divide-by-ten digit extractor, digit store, field counters and the output
// register.
// ----------------------------------------------------------------------------
module udf_datapath #(
  parameter int FIELD_MAX  = udf_pkg::FIELD_MAX_DEF,
  parameter int VALUE_BITS = udf_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  udf_pkg::cmd_t     cmd,
  output udf_pkg::status_t  status,
  udf_in_if.sink            din,
  udf_out_if.source         dout
);
  import udf_pkg::*;

  // Only the low VALUE_BITS bits of the 32-bit field take part.
  localparam int VB   = (VALUE_BITS < INPUT_VALUE_W) ? VALUE_BITS : INPUT_VALUE_W;
  localparam int NDIG = digits_for_bits(VB);
  localparam int NDW  = $clog2(NDIG + 1);
  localparam int SIW  = $clog2(NDIG);
  localparam logic [FIELD_W-1:0] FMAX  = FIELD_W'(FIELD_MAX);
  // floor(t / 10) == (t * RECIP) >> 35 for every 32-bit t.
  localparam logic [31:0]        RECIP = 32'hCCCC_CCCD;

  logic [VB-1:0]       t;
  logic                vzero;
  logic [FIELD_W-1:0]  width_r;
  logic [FIELD_W-1:0]  prec_r;
  logic                has_p_r;
  logic                zflag_r;
  logic                left_r;
  logic [NDW-1:0]      nd;
  logic [3:0]          store [NDIG];
  logic [FIELD_W-1:0]  pad_cnt;
  logic [FIELD_W-1:0]  zero_cnt;
  logic [NDW-1:0]      dig_cnt;
  logic [FIELD_W-1:0]  remain;
  logic [FIELD_W-1:0]  total;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;
  logic                out_empty;
  logic [FIELD_W-1:0]  out_count;

  logic                load;
  logic [31:0]         t_ext;
  logic [63:0]         prod;
  logic [VB-1:0]       q;
  logic [3:0]          q_lo;
  logic [3:0]          q10_lo;
  logic [3:0]          rem;
  logic [FIELD_W-1:0]  fw_clamped;
  logic [FIELD_W-1:0]  md_clamped;
  logic [FIELD_W-1:0]  nd_eff;
  logic [FIELD_W-1:0]  zeros_c;
  logic [FIELD_W-1:0]  body_c;
  logic [FIELD_W-1:0]  pad_c;
  logic [FIELD_W-1:0]  total_c;
  logic [NDW-1:0]      dig_dec;
  logic [CHAR_W-1:0]   pad_ch;
  logic                emit_any;
  logic                is_empty;
  logic                is_last;

  assign load = din.valid && cmd.in_ready;

  // One decimal digit per step; the remainder needs only the low four bits.
  assign t_ext  = 32'(t);
  assign prod   = t_ext * RECIP;
  assign q      = VB'(prod >> 35);
  assign q_lo   = prod[38:35];
  assign q10_lo = {q_lo[0], 3'b000} + {q_lo[2:0], 1'b0};
  assign rem    = t[3:0] - q10_lo;

  assign fw_clamped = (din.field_width > FMAX) ? FMAX : din.field_width;
  assign md_clamped = (din.min_digits > FMAX) ? FMAX : din.min_digits;

  // A zero value with an explicit precision prints no digits at all.
  assign nd_eff  = (vzero && has_p_r) ? '0 : FIELD_W'(nd);
  assign zeros_c = (prec_r > nd_eff) ? prec_r - nd_eff : '0;
  assign body_c  = (prec_r > nd_eff) ? prec_r : nd_eff;
  assign pad_c   = (width_r > body_c) ? width_r - body_c : '0;
  assign total_c = (width_r > body_c) ? width_r : body_c;

  assign dig_dec  = dig_cnt - 1'b1;
  assign pad_ch   = (!left_r && zflag_r && !has_p_r) ? ASCII_ZERO : ASCII_SPACE;
  assign emit_any = (cmd.emit_sel != EM_NONE);
  assign is_empty = (cmd.emit_sel == EM_EMPTY);
  assign is_last  = (remain == FIELD_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_any) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      t       <= din.value[VB-1:0];
      vzero   <= (din.value[VB-1:0] == '0);
      width_r <= din.has_width ? fw_clamped : '0;
      prec_r  <= din.has_precision ? md_clamped : '0;
      has_p_r <= din.has_precision;
      zflag_r <= din.zero_pad;
      left_r  <= din.left_justify;
      nd      <= '0;
    end
    if (cmd.conv_step) begin
      store[nd[SIW-1:0]] <= rem;
      nd                 <= nd + 1'b1;
      t                  <= q;
    end
    if (cmd.setup) begin
      pad_cnt  <= pad_c;
      zero_cnt <= zeros_c;
      dig_cnt  <= nd_eff[NDW-1:0];
      remain   <= total_c;
      total    <= total_c;
    end
    if (emit_any) begin
      // An empty conversion has a zero total, so its count stays zero.
      out_last  <= is_last || is_empty;
      out_empty <= is_empty;
      out_count <= is_last ? total : '0;
      remain    <= remain - 1'b1;
      case (cmd.emit_sel)
        EM_PAD: begin
          out_char <= pad_ch;
          pad_cnt  <= pad_cnt - 1'b1;
        end
        EM_ZERO: begin
          out_char <= ASCII_ZERO;
          zero_cnt <= zero_cnt - 1'b1;
        end
        EM_DIGIT: begin
          out_char <= ASCII_ZERO + {4'b0000, store[dig_dec[SIW-1:0]]};
          dig_cnt  <= dig_dec;
        end
        EM_EMPTY: begin
          out_char <= '0;
        end
        default: begin
          out_char <= '0;
        end
      endcase
    end
  end

  assign din.ready       = cmd.in_ready;
  assign dout.valid      = out_valid;
  assign dout.character  = out_char;
  assign dout.last       = out_last;
  assign dout.empty_res  = out_empty;
  assign dout.char_count = out_count;

  assign status.in_valid   = din.valid;
  assign status.q_zero     = (q == '0);
  assign status.total_zero = (total == '0);
  assign status.left       = left_r;
  assign status.pad_zero   = (pad_cnt == '0);
  assign status.pad_one    = (pad_cnt == FIELD_W'(1));
  assign status.zeros_zero = (zero_cnt == '0);
  assign status.zeros_one  = (zero_cnt == FIELD_W'(1));
  assign status.dig_zero   = (dig_cnt == '0);
  assign status.dig_one    = (dig_cnt == NDW'(1));
  assign status.out_free   = !out_valid || dout.ready;

endmodule
